/* rtl/tsc_pkg.sv */
// Shared widths and constants for the threshold swing counter.
`default_nettype none

package tsc_pkg;

    localparam int COUNT_W          = 32;
    localparam int THR_W            = 32;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [THR_W-1:0]   THR_ONE   = THR_W'(1);

endpackage

`default_nettype wire

/* rtl/threshold_swing_counter.sv */
// Top level of the threshold swing counter: input slice and counting core.
`default_nettype none

// Channel   Direction  Handshake          Word
// s_*       in         s_valid/s_ready    s_sample, s_is_last
// m_*       out        m_valid/m_ready    m_swing_count, m_final_flag
// cfg_*     in         cfg_we (no wait)   cfg_wdata (swing threshold)
//
// Every word goes from acceptance to result through the input register and
// then through the compare-and-update logic into the result register.
// A new word is accepted every cycle while m_ready is high; the
// subtract-and-compare against the threshold sets the clock period.
// Reset (aresetn low, synchronous) empties both registers, clears the
// threshold to zero and puts the search back to its start.
// A stall on m_ready fills the result register and then the input register,
// after which s_ready drops; nothing is lost or repeated.

module threshold_swing_counter #(
    parameter int SAMPLE_WIDTH = tsc_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [tsc_pkg::THR_W-1:0]  cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]    s_sample,
    input  wire logic                       s_is_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [tsc_pkg::COUNT_W-1:0]     m_swing_count,
    output logic                            m_final_flag
);
    import tsc_pkg::*;

    // Word handed from the input register to the core.
    logic                    mid_valid;
    logic                    mid_ready;
    logic [SAMPLE_WIDTH-1:0] mid_sample;
    logic                    mid_is_last;

    tsc_in_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_sample   (s_sample),
        .in_is_last  (s_is_last),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_sample  (mid_sample),
        .out_is_last (mid_is_last)
    );

    // The core holds the phase, extremum and count, and registers each result.
    tsc_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .in_sample  (mid_sample),
        .in_is_last (mid_is_last),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_count  (m_swing_count),
        .out_final  (m_final_flag)
    );

endmodule

`default_nettype wire

/* rtl/tsc_in_stage.sv */
// Input register slice that holds one sample word ahead of the counting core.
`default_nettype none

module tsc_in_stage #(
    parameter int SAMPLE_WIDTH = tsc_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
    input  wire logic                    in_is_last,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0]      out_sample,
    output logic                         out_is_last
);
    import tsc_pkg::*;

    logic                    valid_reg;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic                    last_reg;

    // The slice refills in the same cycle that the core drains it.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sample_reg <= in_sample;
            last_reg   <= in_is_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_sample  = sample_reg;
    assign out_is_last = last_reg;

endmodule

`default_nettype wire

/* rtl/tsc_core.sv */
// Greedy alternating-swing state, threshold register and result register.
`default_nettype none

module tsc_core #(
    parameter int SAMPLE_WIDTH = tsc_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [tsc_pkg::THR_W-1:0]    cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]      in_sample,
    input  wire logic                         in_is_last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [tsc_pkg::COUNT_W-1:0]       out_count,
    output logic                              out_final
);
    import tsc_pkg::*;

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > THR_W) ? DIFF_W : THR_W;

    logic [THR_W-1:0]               thr_reg;
    logic                           seeking_fall_reg, seeking_fall_next;
    logic                           started_reg, started_next;
    logic signed [SAMPLE_WIDTH-1:0] extremum_reg, extremum_next;
    logic [COUNT_W-1:0]             count_reg, count_next;
    logic                           out_valid_reg;
    logic [COUNT_W-1:0]             out_count_reg;
    logic                           out_final_reg;

    logic                           take;
    logic signed [SAMPLE_WIDTH-1:0] s;
    logic signed [DIFF_W-1:0]       s_ext, e_ext, up_diff, down_diff;
    logic [THR_W-1:0]               thr_eff;
    logic                           higher, lower, up_step, down_step;
    logic [COUNT_W-1:0]             count_bumped, count_new;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign s         = in_sample;
    assign s_ext     = DIFF_W'(s);
    assign e_ext     = DIFF_W'(extremum_reg);
    assign up_diff   = s_ext - e_ext;
    assign down_diff = e_ext - s_ext;
    assign higher    = s > extremum_reg;
    assign lower     = s < extremum_reg;
    // A zero threshold behaves as one, so equal samples never count.
    assign thr_eff   = (thr_reg == '0) ? THR_ONE : thr_reg;
    assign up_step   = higher &&
                       (CMP_W'(unsigned'(up_diff)) >= CMP_W'(thr_eff));
    assign down_step = lower &&
                       (CMP_W'(unsigned'(down_diff)) >= CMP_W'(thr_eff));
    assign count_bumped = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    always_comb begin
        seeking_fall_next = seeking_fall_reg;
        extremum_next     = extremum_reg;
        count_new         = count_reg;
        if (!started_reg) begin
            seeking_fall_next = 1'b0;
            extremum_next     = s;
            count_new         = COUNT_W'(1);
        end else if (!seeking_fall_reg) begin
            if (up_step) begin
                count_new         = count_bumped;
                seeking_fall_next = 1'b1;
                extremum_next     = s;
            end else if (lower) begin
                extremum_next = s;
            end
        end else begin
            if (down_step) begin
                count_new         = count_bumped;
                seeking_fall_next = 1'b0;
                extremum_next     = s;
            end else if (higher) begin
                extremum_next = s;
            end
        end
        count_next   = count_new;
        started_next = 1'b1;
        // The end of a sequence puts the search back to its reset state.
        if (in_is_last) begin
            seeking_fall_next = 1'b0;
            extremum_next     = '0;
            count_next        = '0;
            started_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeking_fall_reg <= 1'b0;
            started_reg      <= 1'b0;
            extremum_reg     <= '0;
            count_reg        <= '0;
        end else if (take) begin
            seeking_fall_reg <= seeking_fall_next;
            started_reg      <= started_next;
            extremum_reg     <= extremum_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_count_reg <= count_new;
            out_final_reg <= in_is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;
    assign out_final = out_final_reg;

endmodule

`default_nettype wire
